[rtl/core/bdlp_pkg.sv]
// Shared types and constants of the button debouncer with long-press detection.
`default_nettype none

package bdlp_pkg;

   // Buttons at this index and beyond have no enable bit and no level bit.
   localparam int WIDE_BUTTONS = 8;

   localparam logic [15:0] DEF_DEBOUNCE = 16'd10;
   localparam logic [15:0] DEF_LONG     = 16'd600;

   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_LONG     = 2'd1;
   localparam logic [1:0] CSR_ENABLE   = 2'd2;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_LONG    = 2'd3
   } event_type;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SCAN_END = 6'b000100,
      ST_POP_RD   = 6'b001000,
      ST_POP_Q    = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

endpackage

`default_nettype wire

[rtl/core/bdlp_slot_store.sv]
// Per-button slot memory with one valid bit per entry so that a cleared slot reads as reset.
`default_nettype none

module bdlp_slot_store #(
   parameter int DEPTH = 8,
   parameter int AW = 3,
   parameter int DW = 8,
   parameter logic [DW-1:0] RST_WORD = '0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [DEPTH-1:0] clr,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DW-1:0]    rd_word_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_word_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_ff & ~clr;
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (re) begin
            rd_vld_ff <= valid_ff[raddr];
         end
      end
   end

   // An entry that was never written since its last clear reads as the reset slot.
   assign rdata = rd_vld_ff ? rd_word_ff : RST_WORD;

endmodule

`default_nettype wire

[rtl/core/bdlp_event_queue.sv]
// Event storage: one circular queue of event codes per button, registered read.
`default_nettype none

module bdlp_event_queue #(
   parameter int NUM_BUTTONS = 8,
   parameter int QUEUE_DEPTH = 4,
   parameter int BW = 3,
   parameter int PW = 2
) (
   input  wire logic                clock,
   input  wire logic                we,
   input  wire logic [BW-1:0]       wr_btn,
   input  wire logic [PW-1:0]       wr_ptr,
   input  wire bdlp_pkg::event_type wr_data,
   input  wire logic                re,
   input  wire logic [BW-1:0]       rd_btn,
   input  wire logic [PW-1:0]       rd_ptr,
   output bdlp_pkg::event_type      rd_data
);

   bdlp_pkg::event_type mem [NUM_BUTTONS][QUEUE_DEPTH];
   bdlp_pkg::event_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_btn][wr_ptr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem[rd_btn][rd_ptr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/button_debounce_long_press.sv]
// Top level: sequencer and datapath of the button debouncer with long-press detection.
//
//  Channel | Direction | Signals                         | Contents
//  req     | in        | req_tvalid/tready/tdata/tuser   | scan sample or pop request
//  rsp     | out       | rsp_tvalid/tready/tdata         | one result item per request
//  csr     | in        | csr_we/csr_index/csr_wdata      | register writes, no read-back
//
// A scan walks the button slots through the slot memory, one slot read and one
// write-back per cycle: the result is registered once the walk is through and
// the output register is free.
// A pop goes through slot read, queue read, then the result; a pop of a disabled
// or absent button goes straight to the result.
// Reset is synchronous; the slot memory needs no clearing pass, valid bits stand in.
// A new item is taken once the previous result sits in the output register.
// The block waits with its result while rsp_tready is low.
`default_nettype none

module button_debounce_long_press #(
   parameter int NUM_BUTTONS = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // now_time [31:0], raw_levels [39:32], button_sel [42:40], zero fill [47:43]
   input  wire logic [47:0] req_tdata,
   // req_type [0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // events_raised [3:0], event_code [5:4], is_down [6], held_time [38:7], zero fill [39]
   output logic      [39:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SCAN_N = (NUM_BUTTONS < bdlp_pkg::WIDE_BUTTONS) ?
                           NUM_BUTTONS : bdlp_pkg::WIDE_BUTTONS;

   typedef struct packed {
      logic          stable;
      logic          last_raw;
      logic          long_done;
      logic [31:0]   edge_time;
      logic [31:0]   press_time;
      logic [PW-1:0] head;
      logic [CW-1:0] count;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);
   localparam slot_type SLOT_RST = '{stable: 1'b0, last_raw: 1'b1, long_done: 1'b0,
                                     edge_time: 32'd0, press_time: 32'd0,
                                     head: '0, count: '0};

   // Configuration registers.
   logic [15:0] deb_ff, lng_ff;
   logic [7:0]  en_ff;
   logic [15:0] deb_eff, lng_eff;
   logic [NUM_BUTTONS-1:0] slot_clr;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= bdlp_pkg::DEF_DEBOUNCE;
         lng_ff <= bdlp_pkg::DEF_LONG;
         en_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE: deb_ff <= csr_wdata;
            bdlp_pkg::CSR_LONG:     lng_ff <= csr_wdata;
            bdlp_pkg::CSR_ENABLE:   en_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // A slot whose enable bit rises starts over from its reset contents.
   always_comb begin
      slot_clr = '0;
      for (int i = 0; i < SCAN_N; i++) begin
         slot_clr[i] = csr_we && (csr_index == bdlp_pkg::CSR_ENABLE) &&
                       csr_wdata[i] && !en_ff[i];
      end
   end

   assign deb_eff = (deb_ff == 16'd0) ? bdlp_pkg::DEF_DEBOUNCE : deb_ff;
   assign lng_eff = (lng_ff < deb_eff) ? bdlp_pkg::DEF_LONG : lng_ff;

   // Sequencer and item registers.
   bdlp_pkg::state_type state_ff, state_in;
   logic          req_type_ff;
   logic [31:0]   now_ff;
   logic [7:0]    raw_ff;
   logic [BW-1:0] sel_ff;
   logic [BW-1:0] scan_idx_ff;
   logic          p_vld_ff;
   logic [BW-1:0] p_idx_ff;
   logic [3:0]    ev_cnt_ff;
   logic          has_ev_ff;
   logic          down_ff;
   logic [31:0]   held_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;

   logic          req_acc;
   logic          out_free;
   logic [2:0]    req_sel;
   logic          sel_ok;
   logic [2:0]    p_idx3;

   // Slot memory and event queue ports.
   logic          slot_re, slot_we;
   logic [BW-1:0] slot_raddr, slot_waddr;
   slot_type      slot_wdata, slot_rdata;
   slot_type      scan_nxt, pop_nxt;
   logic          q_we, q_re;
   logic [PW-1:0] q_wptr;
   bdlp_pkg::event_type q_wdata, q_rdata;

   // Scan datapath signals.
   logic          raw_bit, pressed, push;
   logic [31:0]   dt_edge, dt_press;
   logic [CW:0]   tail_sum;
   bdlp_pkg::event_type scan_ev;

   assign req_tready = (state_ff == bdlp_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_sel    = req_tdata[42:40];
   assign sel_ok     = (32'(req_sel) < NUM_BUTTONS) && en_ff[req_sel];
   assign p_idx3     = 3'(p_idx_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdlp_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == bdlp_pkg::REQ_SCAN) begin
                  state_in = bdlp_pkg::ST_SCAN;
               end else if (sel_ok) begin
                  state_in = bdlp_pkg::ST_POP_RD;
               end else begin
                  state_in = bdlp_pkg::ST_DONE;
               end
            end
         end
         bdlp_pkg::ST_SCAN: begin
            if (scan_idx_ff == BW'(SCAN_N - 1)) begin
               state_in = bdlp_pkg::ST_SCAN_END;
            end
         end
         bdlp_pkg::ST_SCAN_END: state_in = bdlp_pkg::ST_DONE;
         bdlp_pkg::ST_POP_RD:   state_in = bdlp_pkg::ST_POP_Q;
         bdlp_pkg::ST_POP_Q:    state_in = bdlp_pkg::ST_DONE;
         bdlp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bdlp_pkg::ST_IDLE;
            end
         end
         default: state_in = bdlp_pkg::ST_IDLE;
      endcase
   end

   // Scan update of one slot, from the word read in the previous cycle.
   always_comb begin
      scan_nxt = slot_rdata;
      raw_bit  = raw_ff[p_idx3];
      pressed  = !raw_bit;
      push     = 1'b0;
      scan_ev  = bdlp_pkg::EV_NONE;
      if (raw_bit != slot_rdata.last_raw) begin
         scan_nxt.last_raw  = raw_bit;
         scan_nxt.edge_time = now_ff;
      end
      dt_edge  = now_ff - scan_nxt.edge_time;
      dt_press = now_ff - slot_rdata.press_time;
      if (dt_edge >= {16'd0, deb_eff}) begin
         if (pressed != slot_rdata.stable) begin
            scan_nxt.stable = pressed;
            push = 1'b1;
            if (pressed) begin
               scan_nxt.press_time = now_ff;
               scan_nxt.long_done  = 1'b0;
               scan_ev = bdlp_pkg::EV_PRESS;
            end else begin
               scan_ev = bdlp_pkg::EV_RELEASE;
            end
         end else if (pressed && !slot_rdata.long_done &&
                      dt_press >= {16'd0, lng_eff}) begin
            scan_nxt.long_done = 1'b1;
            push = 1'b1;
            scan_ev = bdlp_pkg::EV_LONG;
         end
      end
      tail_sum = (CW+1)'(slot_rdata.head) + (CW+1)'(slot_rdata.count);
      if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
      end
      if (push && (slot_rdata.count < CW'(QUEUE_DEPTH))) begin
         scan_nxt.count = slot_rdata.count + CW'(1);
      end
   end

   // Pop update: the oldest event leaves the queue.
   always_comb begin
      pop_nxt = slot_rdata;
      if (slot_rdata.count != '0) begin
         pop_nxt.count = slot_rdata.count - CW'(1);
         if (slot_rdata.head == PW'(QUEUE_DEPTH - 1)) begin
            pop_nxt.head = '0;
         end else begin
            pop_nxt.head = slot_rdata.head + PW'(1);
         end
      end
   end

   always_comb begin
      slot_re    = 1'b0;
      slot_raddr = scan_idx_ff;
      if (state_ff == bdlp_pkg::ST_SCAN) begin
         slot_re = 1'b1;
      end else if (state_ff == bdlp_pkg::ST_POP_RD) begin
         slot_re    = 1'b1;
         slot_raddr = sel_ff;
      end
   end

   always_comb begin
      if (state_ff == bdlp_pkg::ST_POP_Q) begin
         slot_we    = 1'b1;
         slot_waddr = sel_ff;
         slot_wdata = pop_nxt;
      end else begin
         slot_we    = p_vld_ff && en_ff[p_idx3];
         slot_waddr = p_idx_ff;
         slot_wdata = scan_nxt;
      end
   end

   assign q_we    = slot_we && (state_ff != bdlp_pkg::ST_POP_Q) && push &&
                    (slot_rdata.count < CW'(QUEUE_DEPTH));
   assign q_wptr  = PW'(tail_sum);
   assign q_wdata = scan_ev;
   assign q_re    = (state_ff == bdlp_pkg::ST_POP_Q) && (slot_rdata.count != '0);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_type_ff <= req_tuser;
         now_ff      <= req_tdata[31:0];
         raw_ff      <= req_tdata[39:32];
         sel_ff      <= BW'(req_sel);
      end
      if (state_ff == bdlp_pkg::ST_SCAN) begin
         p_idx_ff <= scan_idx_ff;
      end
      if (state_ff == bdlp_pkg::ST_POP_Q) begin
         down_ff <= slot_rdata.stable;
         held_ff <= slot_rdata.stable ? (now_ff - slot_rdata.press_time) : 32'd0;
      end else if (req_acc) begin
         down_ff <= 1'b0;
         held_ff <= 32'd0;
      end
      if ((state_ff == bdlp_pkg::ST_DONE) && out_free) begin
         rsp_data_ff <= {1'b0, held_ff, down_ff,
                         (has_ev_ff ? q_rdata : bdlp_pkg::EV_NONE), ev_cnt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdlp_pkg::ST_IDLE;
         scan_idx_ff  <= '0;
         p_vld_ff     <= 1'b0;
         ev_cnt_ff    <= '0;
         has_ev_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_vld_ff <= (state_ff == bdlp_pkg::ST_SCAN);
         if (req_acc) begin
            scan_idx_ff <= '0;
            ev_cnt_ff   <= '0;
            has_ev_ff   <= 1'b0;
         end else begin
            if (state_ff == bdlp_pkg::ST_SCAN) begin
               scan_idx_ff <= scan_idx_ff + BW'(1);
            end
            // Dropped events on a full queue still count.
            if (p_vld_ff && en_ff[p_idx3] && push) begin
               ev_cnt_ff <= ev_cnt_ff + 4'd1;
            end
            if (state_ff == bdlp_pkg::ST_POP_Q) begin
               has_ev_ff <= (slot_rdata.count != '0);
            end
         end
         if ((state_ff == bdlp_pkg::ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bdlp_slot_store #(
      .DEPTH    (NUM_BUTTONS),
      .AW       (BW),
      .DW       (SLOT_W),
      .RST_WORD (SLOT_RST)
   ) u_slot_store (
      .clock (clock),
      .reset (reset),
      .clr   (slot_clr),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   bdlp_event_queue #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .BW          (BW),
      .PW          (PW)
   ) u_event_queue (
      .clock   (clock),
      .we      (q_we),
      .wr_btn  (p_idx_ff),
      .wr_ptr  (q_wptr),
      .wr_data (q_wdata),
      .re      (q_re),
      .rd_btn  (sel_ff),
      .rd_ptr  (slot_rdata.head),
      .rd_data (q_rdata)
   );

   // The scan pipeline never writes back the slot it is reading in the same cycle.
   a_no_slot_overlap: assert property (@(posedge clock) disable iff (reset)
      slot_we && slot_re |-> slot_waddr != slot_raddr)
      else $error("slot read and write-back hit the same entry");

   // A processed slot always comes from a read issued by the scan walk.
   a_pipe_from_scan: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> $past(state_ff == bdlp_pkg::ST_SCAN))
      else $error("scan stage valid without a scan read");

   // A scan never raises more events than it has slots.
   a_event_bound: assert property (@(posedge clock) disable iff (reset)
      ev_cnt_ff <= 4'(SCAN_N))
      else $error("event count exceeds the number of scanned slots");

   // A pop result never reports an event for a scan item.
   a_pop_only_event: assert property (@(posedge clock) disable iff (reset)
      has_ev_ff && (state_ff == bdlp_pkg::ST_DONE) |-> req_type_ff == bdlp_pkg::REQ_POP)
      else $error("event code pending on a scan item");

endmodule

`default_nettype wire
